// ===== rtl/core/fnvf_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// FNV-1a seen-message filter package
// Shared constants, payload structs and controller/datapath interface types.
// ----------------------------------------------------------------------------
package fnvf_pkg;

    // Table geometry.
    localparam int TABLE_DEPTH = 4096;
    localparam int ADDR_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    // FNV-1a 32-bit constants.
    localparam logic [31:0] FNV_BASIS = 32'd2166136261;
    localparam logic [31:0] FNV_PRIME = 32'd16777619;

    // One request: a message byte and its last-byte mark.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } fnvf_req_t;

    // One result for a completed message.
    typedef struct packed {
        logic        is_fresh;
        logic [31:0] message_hash;
        logic        table_full;
    } fnvf_rsp_t;

    // Controller states.
    typedef enum logic {
        ST_IDLE,
        ST_SEARCH
    } fnvf_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic hash_step;
        logic search_start;
        logic search_step;
        logic report;
    } fnvf_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic hit;
        logic exhausted;
    } fnvf_status_t;

endpackage
`default_nettype wire

// ===== rtl/core/fnvf_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// FNV-1a filter controller
// Sequences byte hashing, the table search on the final byte and the report.
// ----------------------------------------------------------------------------
module fnvf_ctrl
    import fnvf_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         start,
    input  wire logic         last_byte,
    input  wire fnvf_status_t status,
    output logic              busy,
    output fnvf_cmd_t         cmd
);

    fnvf_state_t state_reg;
    fnvf_state_t state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        busy       = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.hash_step = 1'b1;
                    if (last_byte)
                    begin
                        cmd.search_start = 1'b1;
                        state_next       = ST_SEARCH;
                    end
                end
            end
            ST_SEARCH:
            begin
                busy = 1'b1;
                if (status.hit || status.exhausted)
                begin
                    cmd.report = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    cmd.search_step = 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

// ===== rtl/core/fnvf_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// FNV-1a filter datapath
// Running hash, seen-hash table memory, search pointer and result register.
// ----------------------------------------------------------------------------
module fnvf_datapath
    import fnvf_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire fnvf_req_t req,
    input  wire fnvf_cmd_t cmd,
    output fnvf_status_t   status,
    output logic           done,
    output fnvf_rsp_t      result
);

    logic [31:0]      run_hash_reg;
    logic [31:0]      final_hash_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] idx_reg;
    logic             pend_reg;
    logic [31:0]      rdata_reg;
    logic             done_reg;
    fnvf_rsp_t        rsp_reg;

    logic [31:0] seen_mem [TABLE_DEPTH];

    logic [31:0] mixed;
    logic [31:0] hash_next;
    logic        full;
    logic        hit;
    logic        more;
    logic        wr_en;
    logic        rd_en;

    // One FNV-1a round: xor in the byte, then multiply by the prime.
    assign mixed     = run_hash_reg ^ {24'd0, req.data_byte};
    assign hash_next = mixed * FNV_PRIME;

    // Search status.
    assign full  = (count_reg == CNT_W'(TABLE_DEPTH));
    assign hit   = pend_reg && (rdata_reg == final_hash_reg);
    assign more  = (idx_reg < count_reg);
    assign rd_en = cmd.search_step && more;
    assign wr_en = cmd.report && !hit && !full;

    assign status.hit       = hit;
    assign status.exhausted = !more && !pend_reg;

    // Running hash, restarting from the basis after each final byte.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_hash_reg <= FNV_BASIS;
        end
        else if (cmd.hash_step)
        begin
            run_hash_reg <= req.last_byte ? FNV_BASIS : hash_next;
        end
    end

    // Final hash of the message under search.
    always_ff @(posedge clk)
    begin
        if (cmd.hash_step && req.last_byte)
        begin
            final_hash_reg <= hash_next;
        end
    end

    // Search pointer and read-in-flight flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg  <= '0;
            pend_reg <= 1'b0;
        end
        else if (cmd.search_start)
        begin
            idx_reg  <= '0;
            pend_reg <= 1'b0;
        end
        else if (cmd.search_step)
        begin
            pend_reg <= more;
            if (more)
            begin
                idx_reg <= idx_reg + CNT_W'(1);
            end
        end
    end

    // Fill count of the table.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (wr_en)
        begin
            count_reg <= count_reg + CNT_W'(1);
        end
    end

    // Seen-hash memory: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            seen_mem[count_reg[ADDR_W-1:0]] <= final_hash_reg;
        end
        if (rd_en)
        begin
            rdata_reg <= seen_mem[idx_reg[ADDR_W-1:0]];
        end
    end

    // Result strobe.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.report;
        end
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        if (cmd.report)
        begin
            rsp_reg.is_fresh     <= !hit;
            rsp_reg.message_hash <= final_hash_reg;
            rsp_reg.table_full   <= full;
        end
    end

    assign done   = done_reg;
    assign result = rsp_reg;

    // The fill count never passes the table depth.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(TABLE_DEPTH))
        else $error("fill count exceeds table depth");

    // The search pointer never runs past the stored entries.
    a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
        idx_reg <= count_reg)
        else $error("search pointer beyond fill count");

    // A report is followed by exactly one result strobe.
    a_report_done: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.report |=> done)
        else $error("report without result strobe");

    // A stored fresh hash grows the fill count by one.
    a_store_count: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |=> (count_reg == $past(count_reg) + CNT_W'(1)))
        else $error("store did not advance fill count");

endmodule
`default_nettype wire

// ===== rtl/core/fnv1a_seen_message_filter.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// FNV-1a seen-message filter
// Hashes messages byte by byte and flags each one as fresh or a repeat.
// ----------------------------------------------------------------------------
// A byte is taken on a clock edge where start is high and busy is low. Bytes
// without the last-byte mark are hashed as they are taken and busy stays low.
// The final byte starts a sweep of the seen-hash table through its single
// read port: busy stays high until the hash matches a stored entry or every
// stored hash has been read. The result strobe done rises at the same clock
// edge at which busy falls and lasts one cycle; the receiver cannot stall it,
// so it must take the result then. The table holds up to 4096 hashes and is
// empty after reset; once full, new hashes are reported fresh but not stored.
// ----------------------------------------------------------------------------
module fnv1a_seen_message_filter
    import fnvf_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      start,
    input  wire fnvf_req_t req,
    output logic           busy,
    output logic           done,
    output fnvf_rsp_t      result
);

    fnvf_cmd_t    cmd;
    fnvf_status_t status;
    logic         busy_int;

    // Sequencer.
    fnvf_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .last_byte (req.last_byte),
        .status    (status),
        .busy      (busy_int),
        .cmd       (cmd)
    );

    // Hash, table and result datapath.
    fnvf_datapath u_datapath (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (req),
        .cmd    (cmd),
        .status (status),
        .done   (done),
        .result (result)
    );

    assign busy = busy_int;

endmodule
`default_nettype wire
